FILE: rtl/rhpd_pkg.sv
`default_nettype none

package rhpd_pkg;

    localparam int DEF_PIXEL_BITS    = 16;
    localparam int DEF_MAX_DIMENSION = 8192;

    localparam int CODE_MAX_LEN = 16;
    localparam int NUM_SYMBOLS  = 14;
    localparam int RESULTS_MAX  = 2;

    localparam int PIXEL_W       = 16;
    localparam int DIFF_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int WIDTH_PAIRS_W = 13;
    localparam int HEIGHT_ROWS_W = 14;
    localparam int BIAS_W        = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_PAIRS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_ROWS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIAS        = 2'd2;

    // sizes of this value and above carry no extra bits and mean 32768
    localparam logic [4:0]        SIZE_BIG = 5'd16;
    localparam logic [DIFF_W-1:0] DIFF_BIG = 16'h8000;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_WALK,
        FS_EXTRA,
        FS_FINISH
    } front_state_t;

    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic              phase;
        logic              row_odd;
        logic              first_col;
        logic              early_row;
        logic              last;
        logic              eoi;
    } tok_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last;
        logic               eoi;
    } res_t;

    localparam int TOK_W = $bits(tok_t);
    localparam int RES_W = $bits(res_t);

    // number of codes of length li + 1
    function automatic logic [7:0] code_count(input logic [3:0] li);
        logic [7:0] c;
        unique case (li)
            4'd0:    c = 8'd0;
            4'd1:    c = 8'd1;
            4'd2:    c = 8'd5;
            4'd3:    c = 8'd1;
            4'd4:    c = 8'd1;
            4'd5:    c = 8'd1;
            4'd6:    c = 8'd1;
            4'd7:    c = 8'd1;
            4'd8:    c = 8'd1;
            4'd9:    c = 8'd2;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // symbol value in canonical order, zero past the table
    function automatic logic [4:0] code_size(input logic [7:0] idx);
        logic [4:0] s;
        unique case (idx)
            8'd0:    s = 5'd5;
            8'd1:    s = 5'd4;
            8'd2:    s = 5'd3;
            8'd3:    s = 5'd6;
            8'd4:    s = 5'd2;
            8'd5:    s = 5'd7;
            8'd6:    s = 5'd1;
            8'd7:    s = 5'd0;
            8'd8:    s = 5'd8;
            8'd9:    s = 5'd9;
            8'd10:   s = 5'd11;
            8'd11:   s = 5'd10;
            8'd12:   s = 5'd12;
            8'd13:   s = 5'd13;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rhpd_fifo.sv
`default_nettype none

module rhpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rhpd_front.sv
`default_nettype none

module rhpd_front #(
    parameter int MAX_DIMENSION = rhpd_pkg::DEF_MAX_DIMENSION
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [rhpd_pkg::BYTE_W-1:0]          data_byte,
    output logic                                 full,
    input  logic [rhpd_pkg::WIDTH_PAIRS_W-1:0]   width_pairs,
    input  logic [rhpd_pkg::HEIGHT_ROWS_W-1:0]   height_rows,
    input  logic                                 tok_full,
    output logic                                 tok_push,
    output rhpd_pkg::tok_t                       tok
);

    import rhpd_pkg::*;

    localparam int HALF_DIM = MAX_DIMENSION / 2;
    localparam int COL_W    = $clog2(HALF_DIM);
    localparam int EFFW_W   = COL_W + 1;
    localparam int ROW_W    = $clog2(MAX_DIMENSION);
    localparam int EFFH_W   = ROW_W + 1;
    localparam int NCNT_W   = $clog2(RESULTS_MAX + 1);

    front_state_t      state_reg, state_next;
    logic [31:0]       res_reg, res_next;
    logic [5:0]        held_reg, held_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [NCNT_W-1:0] n_reg, n_next;
    logic              pend_valid_reg, pend_valid_next;
    tok_t              pend_reg, pend_next;
    logic [15:0]       code_reg, code_next;
    logic [16:0]       first_reg, first_next;
    logic [7:0]        base_reg, base_next;
    logic [4:0]        len_reg, len_next;
    logic [4:0]        size_reg, size_next;

    logic [EFFW_W-1:0] effw;
    logic [EFFH_W-1:0] effh;
    logic [5:0]        bit_idx;
    logic [15:0]       code_new;
    logic [7:0]        cnt;
    logic [16:0]       diff_off;
    logic              match;
    logic [7:0]        sym_idx;
    logic              size_zero, size_big;
    logic [5:0]        used;
    logic              incomplete;
    logic [5:0]        sh;
    logic [31:0]       extra_all;
    logic [15:0]       m16, extra16;
    logic              sign_bit;
    logic [DIFF_W-1:0] diff;
    logic              col_end, row_end, eoi_now;
    tok_t              new_tok;

    // clamp the image size to what the counters can hold, a zero size counting as one
    always_comb
    begin
        priority if (width_pairs == '0)
            effw = EFFW_W'(1);
        else if (32'(width_pairs) > 32'(HALF_DIM))
            effw = EFFW_W'(HALF_DIM);
        else
            effw = EFFW_W'(width_pairs);
        priority if (height_rows == '0)
            effh = EFFH_W'(1);
        else if (32'(height_rows) > 32'(MAX_DIMENSION))
            effh = EFFH_W'(MAX_DIMENSION);
        else
            effh = EFFH_W'(height_rows);
    end

    // code walk: one bit per cycle, canonical first-code compare
    assign bit_idx  = held_reg - 6'(len_reg);
    assign code_new = {code_reg[14:0], res_reg[bit_idx[4:0]]};
    assign cnt      = code_count(4'(len_reg - 5'd1));
    assign diff_off = {1'b0, code_new} - first_reg;
    assign match    = ({1'b0, code_new} >= first_reg) && (diff_off < 17'(cnt));
    assign sym_idx  = base_reg + diff_off[7:0];

    // extra bits and sign extension
    assign size_zero  = (size_reg == 5'd0);
    assign size_big   = (size_reg >= SIZE_BIG);
    assign used       = (size_zero || size_big) ? 6'(len_reg)
                                                : 6'(len_reg) + 6'(size_reg);
    assign incomplete = (used > held_reg);
    assign sh         = held_reg - used;
    assign extra_all  = res_reg >> sh[4:0];
    assign m16        = 16'((17'd1 << size_reg) - 17'd1);
    assign extra16    = extra_all[15:0] & m16;
    assign sign_bit   = |(extra16 & ~(m16 >> 1));

    always_comb
    begin
        priority if (size_zero)
            diff = '0;
        else if (size_big)
            diff = DIFF_BIG;
        else if (sign_bit)
            diff = extra16;
        else
            diff = extra16 - m16;
    end

    assign col_end = ((EFFW_W'(col_reg) + 1'b1) >= effw);
    assign row_end = ((EFFH_W'(row_reg) + 1'b1) >= effh);
    assign eoi_now = phase_reg && col_end && row_end;

    always_comb
    begin
        new_tok.diff      = diff;
        new_tok.phase     = phase_reg;
        new_tok.row_odd   = row_reg[0];
        new_tok.first_col = (col_reg == '0);
        new_tok.early_row = (row_reg < ROW_W'(2));
        new_tok.last      = 1'b0;
        new_tok.eoi       = eoi_now;
    end

    assign full = (state_reg != FS_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        res_next        = res_reg;
        held_next       = held_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        phase_next      = phase_reg;
        done_next       = done_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        code_next       = code_reg;
        first_next      = first_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        size_next       = size_reg;
        tok_push        = 1'b0;
        tok             = pend_reg;

        unique case (state_reg)
            FS_IDLE:
            begin
                // beats after the image are taken and dropped
                if (push && !done_reg)
                begin
                    res_next   = {res_reg[23:0], data_byte};
                    held_next  = (held_reg > 6'd24) ? 6'd32 : held_reg + 6'd8;
                    n_next     = '0;
                    code_next  = '0;
                    first_next = '0;
                    base_next  = '0;
                    len_next   = 5'd1;
                    state_next = FS_WALK;
                end
            end

            FS_WALK:
            begin
                if (6'(len_reg) > held_reg)
                begin
                    state_next = FS_FINISH;
                end
                else
                begin
                    code_next = code_new;
                    priority if (match)
                    begin
                        size_next  = code_size(sym_idx);
                        state_next = FS_EXTRA;
                    end
                    else if (len_reg == 5'(CODE_MAX_LEN))
                    begin
                        // no code matched: zero difference over the full length
                        size_next  = '0;
                        state_next = FS_EXTRA;
                    end
                    else
                    begin
                        base_next  = base_reg + cnt;
                        first_next = (first_reg + 17'(cnt)) << 1;
                        len_next   = len_reg + 5'd1;
                    end
                end
            end

            FS_EXTRA:
            begin
                priority if (incomplete)
                begin
                    state_next = FS_FINISH;
                end
                else if (!pend_valid_reg || !tok_full)
                begin
                    held_next = held_reg - used;
                    tok_push  = pend_valid_reg;
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (col_end)
                        begin
                            col_next = '0;
                            if (row_end)
                                done_next = 1'b1;
                            else
                                row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    // hold the newest beat back until we know if it closes the run
                    pend_next       = new_tok;
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + 1'b1;
                    if (eoi_now || (n_reg + 1'b1 == NCNT_W'(RESULTS_MAX)))
                    begin
                        state_next = FS_FINISH;
                    end
                    else
                    begin
                        code_next  = '0;
                        first_next = '0;
                        base_next  = '0;
                        len_next   = 5'd1;
                        state_next = FS_WALK;
                    end
                end
            end

            FS_FINISH:
            begin
                tok.last = 1'b1;
                if (!pend_valid_reg)
                begin
                    state_next = FS_IDLE;
                end
                else if (!tok_full)
                begin
                    tok_push        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = FS_IDLE;
                end
            end

            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FS_IDLE;
            res_reg        <= '0;
            held_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            phase_reg      <= 1'b0;
            done_reg       <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            code_reg       <= '0;
            first_reg      <= '0;
            base_reg       <= '0;
            len_reg        <= 5'd1;
            size_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            res_reg        <= res_next;
            held_reg       <= held_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            phase_reg      <= phase_next;
            done_reg       <= done_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            code_reg       <= code_next;
            first_reg      <= first_next;
            base_reg       <= base_next;
            len_reg        <= len_next;
            size_reg       <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

FILE: rtl/rhpd_back.sv
`default_nettype none

module rhpd_back #(
    parameter int PIXEL_BITS = rhpd_pkg::DEF_PIXEL_BITS
) (
    input  logic                        clk,
    input  logic                        tok_valid,
    input  rhpd_pkg::tok_t              tok,
    input  logic [rhpd_pkg::BIAS_W-1:0] bias,
    output logic                        tok_pop,
    input  logic                        out_full,
    output logic                        out_push,
    output rhpd_pkg::res_t              res
);

    import rhpd_pkg::*;

    logic [PIXEL_BITS-1:0] left_reg [2];
    logic [PIXEL_BITS-1:0] hist_reg [4];
    logic [PIXEL_BITS-1:0] pred;
    logic [PIXEL_BITS-1:0] pix;
    logic [1:0]            slot;
    logic                  go;

    assign go       = tok_valid && !out_full;
    assign tok_pop  = go;
    assign out_push = go;
    assign slot     = {tok.row_odd, tok.phase};

    always_comb
    begin
        priority if (tok.first_col && tok.early_row)
            pred = bias[PIXEL_BITS-1:0];
        else if (tok.first_col)
            pred = hist_reg[slot];
        else
            pred = left_reg[tok.phase];
    end

    // wraps at the pixel width
    assign pix = pred + tok.diff[PIXEL_BITS-1:0];

    always_comb
    begin
        res.pixel = PIXEL_W'(pix);
        res.last  = tok.last;
        res.eoi   = tok.eoi;
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            left_reg[tok.phase] <= pix;
            if (tok.first_col)
            begin
                hist_reg[slot] <= pix;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/raw_huffman_predictive_decoder.sv
// channel   direction  handshake       payload
// input     in         push / full     data_byte[7:0]
// result    out        pop / empty     pixel[15:0], last_in_run, end_of_image
// config    in         wr_en           wr_index[1:0], wr_data[15:0]
//
// the front end takes a byte only when idle, then walks the codes in its reservoir bit by
// bit until the bits run short or a run closes; a byte after the image is taken and dropped
// the back end turns one queued difference into a pixel every cycle while the result queue has room
// rst_n is asynchronous: empty reservoir, position at row 0 column 0, queues empty
// the front end waits on a full difference queue, the back end on a full result queue
`default_nettype none

module raw_huffman_predictive_decoder #(
    parameter int PIXEL_BITS    = rhpd_pkg::DEF_PIXEL_BITS,
    parameter int MAX_DIMENSION = rhpd_pkg::DEF_MAX_DIMENSION
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [rhpd_pkg::BYTE_W-1:0]       data_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic [rhpd_pkg::PIXEL_W-1:0]      pixel,
    output logic                              last_in_run,
    output logic                              end_of_image,
    input  logic                              wr_en,
    input  logic [rhpd_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [rhpd_pkg::CFG_DATA_W-1:0]   wr_data
);

    import rhpd_pkg::*;

    logic [WIDTH_PAIRS_W-1:0] width_pairs_reg, width_pairs_next;
    logic [HEIGHT_ROWS_W-1:0] height_rows_reg, height_rows_next;
    logic [BIAS_W-1:0]        bias_reg, bias_next;

    tok_t             front_tok, back_tok;
    logic [TOK_W-1:0] back_tok_bits;
    logic             tok_push, tok_full, tok_empty, tok_pop;
    res_t             back_res, out_res;
    logic [RES_W-1:0] out_bits;
    logic             out_push, out_full;

    always_comb
    begin
        width_pairs_next = width_pairs_reg;
        height_rows_next = height_rows_reg;
        bias_next        = bias_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_WIDTH_PAIRS: width_pairs_next = wr_data[WIDTH_PAIRS_W-1:0];
                REG_HEIGHT_ROWS: height_rows_next = wr_data[HEIGHT_ROWS_W-1:0];
                REG_BIAS:        bias_next        = wr_data[BIAS_W-1:0];
                default:         bias_next        = bias_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_pairs_reg <= WIDTH_PAIRS_W'(1);
            height_rows_reg <= HEIGHT_ROWS_W'(1);
            bias_reg        <= '0;
        end
        else
        begin
            width_pairs_reg <= width_pairs_next;
            height_rows_reg <= height_rows_next;
            bias_reg        <= bias_next;
        end
    end

    rhpd_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .data_byte   (data_byte),
        .full        (full),
        .width_pairs (width_pairs_reg),
        .height_rows (height_rows_reg),
        .tok_full    (tok_full),
        .tok_push    (tok_push),
        .tok         (front_tok)
    );

    rhpd_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (2)
    ) u_tok_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_push),
        .wr_data (front_tok),
        .full    (tok_full),
        .rd_en   (tok_pop),
        .rd_data (back_tok_bits),
        .empty   (tok_empty)
    );

    assign back_tok = back_tok_bits;

    rhpd_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .tok_valid (!tok_empty),
        .tok       (back_tok),
        .bias      (bias_reg),
        .tok_pop   (tok_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .res       (back_res)
    );

    rhpd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (back_res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_bits),
        .empty   (empty)
    );

    assign out_res      = out_bits;
    assign pixel        = out_res.pixel;
    assign last_in_run  = out_res.last;
    assign end_of_image = out_res.eoi;

`ifndef NO_ASSERTIONS
    a_tok_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        tok_push |-> !tok_full)
        else $error("difference queue written while full");

    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result queue written while full");

    a_eoi_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_image) |-> last_in_run)
        else $error("final pixel of the image does not close its run");

    a_back_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !tok_empty)
        else $error("pixel produced without a queued difference");
`endif

endmodule

`default_nettype wire
